// ===== hdl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fcfsd_pkg.sv =====
// types, codes and helpers shared by the dispatcher modules
package fcfsd_pkg;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 152;

  // phase commands from controller to datapath
  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_CLEAR  = 4'd1,
    OP_LOAD   = 4'd2,
    OP_CFREE  = 4'd3,
    OP_SELECT = 4'd4,
    OP_ASSIGN = 4'd5,
    OP_IO     = 4'd6,
    OP_CSTEP  = 4'd7,
    OP_FINAL  = 4'd8
  } op_e;

  typedef struct packed {
    op_e  op;
    logic start;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic done;
  } sts_t;

  typedef struct packed {
    logic pending;
    logic arrived;
    logic loaded;
  } fl_t;

  // per-slot run state word
  typedef struct packed {
    fl_t         fl;
    logic [15:0] prog;
    logic [7:0]  pos;
  } pstate_t;

  localparam int PSTATE_W = 27;

  typedef struct packed {
    logic        op;
    logic [5:0]  ps;
    logic [4:0]  bs;
    logic [15:0] pid;
    logic [15:0] arr;
    logic [15:0] blen;
    logic        fin;
  } item_t;

  typedef struct packed {
    logic [15:0] last_finished_id;
    logic        load_rejected;
    logic [31:0] busy_total;
    logic [31:0] turnaround_total;
    logic [31:0] wait_total;
    logic        all_done;
    logic [2:0]  busy_cores;
    logic [31:0] time_now;
  } result_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ===== hdl/fcfsd_ram.sv =====
// generic single-write, single-read ram with registered read data
module fcfsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/fcfsd_ctrl.sv =====
// phase sequencer of the dispatcher
module fcfsd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_op,
  input  logic                out_room,
  input  fcfsd_pkg::sts_t     sts,
  output fcfsd_pkg::cmd_t     cmd,
  output logic                in_ready,
  output logic                out_load
);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_LOAD   = 10'b00_0000_0100,
    S_CFREE  = 10'b00_0000_1000,
    S_SELECT = 10'b00_0001_0000,
    S_ASSIGN = 10'b00_0010_0000,
    S_IO     = 10'b00_0100_0000,
    S_CSTEP  = 10'b00_1000_0000,
    S_FINAL  = 10'b01_0000_0000,
    S_EMIT   = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   fresh_r, fresh_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    cmd.op    = fcfsd_pkg::OP_NONE;
    cmd.start = fresh_r;
    cmd.capture = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.op = fcfsd_pkg::OP_CLEAR;
        if (sts.done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = in_op ? S_CFREE : S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.op = fcfsd_pkg::OP_LOAD;
        state_nxt = S_EMIT;
      end
      S_CFREE: begin
        cmd.op = fcfsd_pkg::OP_CFREE;
        if (sts.done) begin
          state_nxt = S_SELECT;
        end
      end
      S_SELECT: begin
        cmd.op = fcfsd_pkg::OP_SELECT;
        if (sts.done) begin
          state_nxt = S_ASSIGN;
        end
      end
      S_ASSIGN: begin
        cmd.op = fcfsd_pkg::OP_ASSIGN;
        if (sts.done) begin
          state_nxt = S_IO;
        end
      end
      S_IO: begin
        cmd.op = fcfsd_pkg::OP_IO;
        if (sts.done) begin
          state_nxt = S_CSTEP;
        end
      end
      S_CSTEP: begin
        cmd.op = fcfsd_pkg::OP_CSTEP;
        if (sts.done) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.op = fcfsd_pkg::OP_FINAL;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_room) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    fresh_nxt = (state_nxt != state_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      fresh_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      fresh_r <= fresh_nxt;
    end
  end

endmodule

// ===== hdl/fcfsd_dp.sv =====
// dispatcher datapath: process tables, queues, cores and totals
module fcfsd_dp #(
  parameter int P = 64,
  parameter int C = 4,
  parameter int B = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fcfsd_pkg::cmd_t     cmd,
  input  fcfsd_pkg::item_t    item,
  output fcfsd_pkg::sts_t     sts,
  output fcfsd_pkg::result_t  res
);

  localparam int SW  = $clog2(P);
  localparam int SIW = $clog2(P + 1);
  localparam int CW  = (C > 1) ? $clog2(C) : 1;
  localparam int CIW = $clog2(C + 1);
  localparam int IW  = (SIW > CIW) ? SIW : CIW;
  localparam int BW  = (B > 1) ? $clog2(B) : 1;
  localparam int BA  = $clog2(P * B);
  localparam int KW  = 16 + SW;

  // captured item
  fcfsd_pkg::item_t cap_r;

  // control and totals
  logic              running_r, running_nxt;
  logic [31:0]       tick_r, tick_nxt;
  logic [31:0]       wait_r, wait_nxt;
  logic [31:0]       turn_r, turn_nxt;
  logic [31:0]       bsum_r, bsum_nxt;
  logic [15:0]       last_id_r, last_id_nxt;
  logic              rej_r, rej_nxt;
  logic [C-1:0]      busy_r, busy_nxt;
  logic [SW-1:0]     cslot_r [C];
  logic [SW-1:0]     cslot_nxt [C];
  logic [SW-1:0]     rq_head_r, rq_head_nxt, rq_tail_r, rq_tail_nxt;
  logic [SIW-1:0]    rq_cnt_r, rq_cnt_nxt;
  logic [SW-1:0]     io_head_r, io_head_nxt, io_tail_r, io_tail_nxt;
  logic [SIW-1:0]    io_cnt_r, io_cnt_nxt;
  logic              pend_any_r, pend_any_nxt;
  logic              unarr_r, unarr_nxt;

  // phase engine state
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [1:0]        step_r, step_nxt;
  logic              pv_r, pv_nxt;
  logic [SW-1:0]     ps_r, ps_nxt;
  logic              pass0_r, pass0_nxt;
  logic              thr_v_r, thr_v_nxt;
  logic [KW-1:0]     thr_r, thr_nxt;
  logic              best_v_r, best_v_nxt;
  logic [KW-1:0]     best_r, best_nxt;
  logic [SW-1:0]     cur_r, cur_nxt;
  logic [SIW-1:0]    io_left_r, io_left_nxt;

  // ram ports
  logic              ld_we, tot_we, st_we, slot_re;
  logic [SW-1:0]     ld_wa, st_wa, slot_ra;
  fcfsd_pkg::pstate_t st_wd, st_rd;
  logic [fcfsd_pkg::PSTATE_W-1:0] st_rd_raw;
  logic [15:0]       ident_rd, arr_rd;
  logic [5:0]        tot_rd;
  logic              bu_we, bu_re;
  logic [BA-1:0]     bu_wa, bu_ra;
  logic [15:0]       bu_rd;
  logic              rq_we, rq_re, io_we, io_re;
  logic [SW-1:0]     rq_wd, rq_rd, io_wd, io_rd;

  // shared burst-check, key and status terms
  logic [15:0]       len_c;
  logic              complete_c;
  logic [7:0]        newpos_c;
  logic              more_c;
  logic [15:0]       prog_inc_c;
  logic [31:0]       turn_add_c;
  logic [BA-1:0]     bu_addr_c, ld_bu_addr_c;
  logic [KW-1:0]     key_c;
  fcfsd_pkg::fl_t    fl_c;
  logic [4:0]        nbusy_c;
  logic              all_done_c;
  logic              ld_ok_c;
  logic [CW-1:0]     cidx;

  function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] x);
    return (x == SW'(P - 1)) ? '0 : x + 1'b1;
  endfunction

  fcfsd_ram #(.WIDTH(16), .DEPTH(P)) u_ident (
    .clk, .wr_en(ld_we), .wr_addr(ld_wa), .wr_data(cap_r.pid),
    .rd_en(slot_re), .rd_addr(slot_ra), .rd_data(ident_rd));
  fcfsd_ram #(.WIDTH(16), .DEPTH(P)) u_arrival (
    .clk, .wr_en(ld_we), .wr_addr(ld_wa), .wr_data(cap_r.arr),
    .rd_en(slot_re), .rd_addr(slot_ra), .rd_data(arr_rd));
  fcfsd_ram #(.WIDTH(6), .DEPTH(P)) u_total (
    .clk, .wr_en(tot_we), .wr_addr(ld_wa), .wr_data({1'b0, cap_r.bs} + 6'd1),
    .rd_en(slot_re), .rd_addr(slot_ra), .rd_data(tot_rd));
  fcfsd_ram #(.WIDTH(fcfsd_pkg::PSTATE_W), .DEPTH(P)) u_state (
    .clk, .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
    .rd_en(slot_re), .rd_addr(slot_ra), .rd_data(st_rd_raw));
  fcfsd_ram #(.WIDTH(16), .DEPTH(P * B)) u_burst (
    .clk, .wr_en(bu_we), .wr_addr(bu_wa), .wr_data(cap_r.blen),
    .rd_en(bu_re), .rd_addr(bu_ra), .rd_data(bu_rd));
  fcfsd_ram #(.WIDTH(SW), .DEPTH(P)) u_ready (
    .clk, .wr_en(rq_we), .wr_addr(rq_tail_r), .wr_data(rq_wd),
    .rd_en(rq_re), .rd_addr(rq_head_r), .rd_data(rq_rd));
  fcfsd_ram #(.WIDTH(SW), .DEPTH(P)) u_io (
    .clk, .wr_en(io_we), .wr_addr(io_tail_r), .wr_data(io_wd),
    .rd_en(io_re), .rd_addr(io_head_r), .rd_data(io_rd));

  assign st_rd = fcfsd_pkg::pstate_t'(st_rd_raw);

  assign cidx       = idx_r[CW-1:0];
  assign len_c      = (st_rd.pos < 8'(B)) ? bu_rd : 16'd0;
  assign complete_c = (st_rd.prog >= len_c);
  assign newpos_c   = (st_rd.pos == 8'hFF) ? st_rd.pos : st_rd.pos + 8'd1;
  assign more_c     = (newpos_c < {2'b00, tot_rd});
  assign prog_inc_c = (st_rd.prog == 16'hFFFF) ? st_rd.prog : st_rd.prog + 16'd1;
  assign turn_add_c = fcfsd_pkg::sat_add(turn_r, tick_r - {16'd0, arr_rd});
  assign bu_addr_c  = BA'(cur_r) * BA'(B) + BA'(st_rd.pos[BW-1:0]);
  assign ld_bu_addr_c = BA'(SW'(cap_r.ps)) * BA'(B) + BA'(cap_r.bs);
  assign key_c      = {ident_rd, ps_r};
  assign nbusy_c    = 5'($countones(busy_r));
  assign ld_ok_c    = (32'(cap_r.ps) < P) && (32'(cap_r.bs) < B);
  assign all_done_c = (busy_r == '0) && (io_cnt_r == '0) && (rq_cnt_r == '0) &&
                      !pend_any_r && !unarr_r;

  always_comb begin
    running_nxt = running_r;  tick_nxt = tick_r;  wait_nxt = wait_r;
    turn_nxt = turn_r;  bsum_nxt = bsum_r;  last_id_nxt = last_id_r;
    rej_nxt = rej_r;  busy_nxt = busy_r;  cslot_nxt = cslot_r;
    rq_head_nxt = rq_head_r;  rq_tail_nxt = rq_tail_r;  rq_cnt_nxt = rq_cnt_r;
    io_head_nxt = io_head_r;  io_tail_nxt = io_tail_r;  io_cnt_nxt = io_cnt_r;
    pend_any_nxt = pend_any_r;  unarr_nxt = unarr_r;
    idx_nxt = idx_r;  step_nxt = step_r;  pv_nxt = pv_r;  ps_nxt = ps_r;
    pass0_nxt = pass0_r;  thr_v_nxt = thr_v_r;  thr_nxt = thr_r;
    best_v_nxt = best_v_r;  best_nxt = best_r;  cur_nxt = cur_r;
    io_left_nxt = io_left_r;
    ld_we = 1'b0;  tot_we = 1'b0;  ld_wa = SW'(cap_r.ps);
    st_we = 1'b0;  st_wa = cur_r;  st_wd = '0;
    slot_re = 1'b0;  slot_ra = cur_r;
    bu_we = 1'b0;  bu_wa = ld_bu_addr_c;  bu_re = 1'b0;  bu_ra = bu_addr_c;
    rq_we = 1'b0;  rq_wd = best_r[SW-1:0];  rq_re = 1'b0;
    io_we = 1'b0;  io_wd = cur_r;  io_re = 1'b0;
    fl_c = st_rd.fl;
    sts.done = 1'b0;

    case (cmd.op)
      fcfsd_pkg::OP_CLEAR: begin
        if (cmd.start) begin
          idx_nxt = '0;
        end else begin
          st_we = 1'b1;
          st_wa = idx_r[SW-1:0];
          st_wd = '0;
          idx_nxt = idx_r + 1'b1;
          sts.done = (idx_r == IW'(P - 1));
        end
      end

      fcfsd_pkg::OP_LOAD: begin
        sts.done = 1'b1;
        rej_nxt = running_r;
        if (!running_r && ld_ok_c) begin
          ld_we = 1'b1;
          bu_we = 1'b1;
          tot_we = cap_r.fin;
          st_we = 1'b1;
          st_wa = SW'(cap_r.ps);
          st_wd = '0;
          st_wd.fl.loaded = 1'b1;
          unarr_nxt = 1'b1;
        end
      end

      fcfsd_pkg::OP_CFREE: begin
        if (cmd.start) begin
          idx_nxt = '0;  step_nxt = '0;  running_nxt = 1'b1;  rej_nxt = 1'b0;
        end else begin
          case (step_r)
            2'd0: begin
              if (idx_r == IW'(C)) begin
                sts.done = 1'b1;
              end else if (busy_r[cidx]) begin
                cur_nxt = cslot_r[cidx];
                slot_re = 1'b1;
                slot_ra = cslot_r[cidx];
                step_nxt = 2'd1;
              end else begin
                idx_nxt = idx_r + 1'b1;
              end
            end
            2'd1: begin
              bu_re = (st_rd.pos < 8'(B));
              step_nxt = 2'd2;
            end
            default: begin
              if (complete_c) begin
                st_we = 1'b1;
                st_wd = {st_rd.fl, 16'd0, newpos_c};
                if (more_c) begin
                  if (io_cnt_r < SIW'(P)) begin
                    io_we = 1'b1;
                    io_tail_nxt = wrap_inc(io_tail_r);
                    io_cnt_nxt = io_cnt_r + 1'b1;
                  end
                end else begin
                  turn_nxt = turn_add_c;
                  last_id_nxt = ident_rd;
                end
                busy_nxt[cidx] = 1'b0;
              end
              idx_nxt = idx_r + 1'b1;
              step_nxt = 2'd0;
            end
          endcase
        end
      end

      fcfsd_pkg::OP_SELECT: begin
        if (cmd.start) begin
          idx_nxt = '0;  pv_nxt = 1'b0;  pass0_nxt = 1'b1;  thr_v_nxt = 1'b0;
          best_v_nxt = 1'b0;  unarr_nxt = 1'b0;  pend_any_nxt = 1'b0;
        end else begin
          // issue side: one slot read per cycle
          if (idx_r < IW'(P)) begin
            slot_re = 1'b1;
            slot_ra = idx_r[SW-1:0];
            ps_nxt = idx_r[SW-1:0];
            idx_nxt = idx_r + 1'b1;
            pv_nxt = 1'b1;
          end else begin
            pv_nxt = 1'b0;
          end
          // process side: admit, retire last pick, track next smallest key
          if (pv_r) begin
            if (pass0_r && fl_c.loaded && !fl_c.arrived &&
                ({16'd0, arr_rd} <= tick_r)) begin
              fl_c.arrived = 1'b1;
              fl_c.pending = 1'b1;
            end
            if (pass0_r && fl_c.loaded && !fl_c.arrived) begin
              unarr_nxt = 1'b1;
            end
            if (thr_v_r && (key_c == thr_r)) begin
              fl_c.pending = 1'b0;
            end
            st_we = 1'b1;
            st_wa = ps_r;
            st_wd = {fl_c, st_rd.prog, st_rd.pos};
            if (fl_c.pending && (!thr_v_r || (key_c > thr_r)) &&
                (!best_v_r || (key_c < best_r))) begin
              best_v_nxt = 1'b1;
              best_nxt = key_c;
            end
          end
          if ((idx_r == IW'(P)) && !pv_r) begin
            if (best_v_r) begin
              if (rq_cnt_r < SIW'(P)) begin
                rq_we = 1'b1;
                rq_tail_nxt = wrap_inc(rq_tail_r);
                rq_cnt_nxt = rq_cnt_r + 1'b1;
              end
              thr_nxt = best_r;
              thr_v_nxt = 1'b1;
              best_v_nxt = 1'b0;
              pass0_nxt = 1'b0;
              idx_nxt = '0;
            end else begin
              sts.done = 1'b1;
            end
          end
        end
      end

      fcfsd_pkg::OP_ASSIGN: begin
        if (cmd.start) begin
          idx_nxt = '0;  step_nxt = '0;
        end else if (step_r == 2'd0) begin
          if (idx_r == IW'(C)) begin
            wait_nxt = fcfsd_pkg::sat_add(wait_r, 32'(rq_cnt_r));
            sts.done = 1'b1;
          end else if (!busy_r[cidx] && (rq_cnt_r != '0)) begin
            rq_re = 1'b1;
            step_nxt = 2'd1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          cslot_nxt[cidx] = rq_rd;
          busy_nxt[cidx] = 1'b1;
          rq_head_nxt = wrap_inc(rq_head_r);
          rq_cnt_nxt = rq_cnt_r - 1'b1;
          idx_nxt = idx_r + 1'b1;
          step_nxt = 2'd0;
        end
      end

      fcfsd_pkg::OP_IO: begin
        if (cmd.start) begin
          step_nxt = '0;  io_left_nxt = io_cnt_r;
        end else begin
          case (step_r)
            2'd0: begin
              if (io_left_r == '0) begin
                sts.done = 1'b1;
              end else begin
                io_re = 1'b1;
                step_nxt = 2'd1;
              end
            end
            2'd1: begin
              cur_nxt = io_rd;
              slot_re = 1'b1;
              slot_ra = io_rd;
              io_head_nxt = wrap_inc(io_head_r);
              io_cnt_nxt = io_cnt_r - 1'b1;
              io_left_nxt = io_left_r - 1'b1;
              step_nxt = 2'd2;
            end
            2'd2: begin
              bu_re = (st_rd.pos < 8'(B));
              step_nxt = 2'd3;
            end
            default: begin
              st_we = 1'b1;
              if (complete_c) begin
                fl_c.pending = fl_c.pending | more_c;
                st_wd = {fl_c, 16'd0, newpos_c};
                if (more_c) begin
                  pend_any_nxt = 1'b1;
                end else begin
                  turn_nxt = turn_add_c;
                  last_id_nxt = ident_rd;
                end
              end else begin
                // still in i/o: requeue at the tail and count this tick
                st_wd = {st_rd.fl, prog_inc_c, st_rd.pos};
                io_we = 1'b1;
                io_tail_nxt = wrap_inc(io_tail_r);
                io_cnt_nxt = io_cnt_r + 1'b1;
              end
              step_nxt = 2'd0;
            end
          endcase
        end
      end

      fcfsd_pkg::OP_CSTEP: begin
        if (cmd.start) begin
          idx_nxt = '0;  step_nxt = '0;
        end else if (step_r == 2'd0) begin
          if (idx_r == IW'(C)) begin
            bsum_nxt = fcfsd_pkg::sat_add(bsum_r, {27'd0, nbusy_c});
            sts.done = 1'b1;
          end else if (busy_r[cidx]) begin
            cur_nxt = cslot_r[cidx];
            slot_re = 1'b1;
            slot_ra = cslot_r[cidx];
            step_nxt = 2'd1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          st_we = 1'b1;
          st_wd = {st_rd.fl, prog_inc_c, st_rd.pos};
          idx_nxt = idx_r + 1'b1;
          step_nxt = 2'd0;
        end
      end

      fcfsd_pkg::OP_FINAL: begin
        sts.done = 1'b1;
        if (!all_done_c && (tick_r != 32'hFFFF_FFFF)) begin
          tick_nxt = tick_r + 32'd1;
        end
      end

      default: begin
        sts.done = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;  tick_r <= '0;  wait_r <= '0;  turn_r <= '0;
      bsum_r <= '0;  last_id_r <= '0;  rej_r <= 1'b0;  busy_r <= '0;
      rq_head_r <= '0;  rq_tail_r <= '0;  rq_cnt_r <= '0;
      io_head_r <= '0;  io_tail_r <= '0;  io_cnt_r <= '0;
      pend_any_r <= 1'b0;  unarr_r <= 1'b0;
      idx_r <= '0;  step_r <= '0;  pv_r <= 1'b0;  pass0_r <= 1'b0;
      thr_v_r <= 1'b0;  best_v_r <= 1'b0;  io_left_r <= '0;
    end else begin
      running_r <= running_nxt;  tick_r <= tick_nxt;  wait_r <= wait_nxt;
      turn_r <= turn_nxt;  bsum_r <= bsum_nxt;  last_id_r <= last_id_nxt;
      rej_r <= rej_nxt;  busy_r <= busy_nxt;
      rq_head_r <= rq_head_nxt;  rq_tail_r <= rq_tail_nxt;  rq_cnt_r <= rq_cnt_nxt;
      io_head_r <= io_head_nxt;  io_tail_r <= io_tail_nxt;  io_cnt_r <= io_cnt_nxt;
      pend_any_r <= pend_any_nxt;  unarr_r <= unarr_nxt;
      idx_r <= idx_nxt;  step_r <= step_nxt;  pv_r <= pv_nxt;  pass0_r <= pass0_nxt;
      thr_v_r <= thr_v_nxt;  best_v_r <= best_v_nxt;  io_left_r <= io_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_r <= item;
    end
    cslot_r <= cslot_nxt;
    ps_r    <= ps_nxt;
    thr_r   <= thr_nxt;
    best_r  <= best_nxt;
    cur_r   <= cur_nxt;
  end

  assign res.time_now         = tick_r;
  assign res.busy_cores       = nbusy_c[2:0];
  assign res.all_done         = all_done_c;
  assign res.wait_total       = wait_r;
  assign res.turnaround_total = turn_r;
  assign res.busy_total       = bsum_r;
  assign res.load_rejected    = rej_r;
  assign res.last_finished_id = last_id_r;

endmodule

// ===== hdl/fcfs_multicore_dispatcher_core.sv =====
// top level of the first-come-first-served multicore dispatcher
//
// input stream: one word per item. in_tuser is the operation (0 load one
// burst of a process, 1 advance one tick), in_tlast marks the final burst of
// the process, in_tdata carries slot, burst index, id, arrival and length.
// output stream: exactly one word per input word, in order, holding the tick
// count, busy cores, the done flag, the three saturating totals, the load
// reject flag and the last finished id.
// after reset the per-slot run state is swept to zero, one slot per cycle;
// in_tready stays low until the sweep is over.
// a tick word runs through its phases one after another, with one read port
// per table setting the pace: retire finished bursts on busy cores, order
// the pending processes by id, feed idle cores from the ready queue, service
// each entry of the i/o queue, count progress on busy cores, then advance the
// tick count unless all work is done.
// the result sits in an output register; the next input word is taken while
// it waits. if out_tready stays low, the following result is held back and
// the block stops taking input until the register drains.
`include "assert_macros.svh"

module fcfs_multicore_dispatcher_core #(
  parameter int PROCESS_SLOTS      = 64,
  parameter int CORES              = 4,
  parameter int BURSTS_PER_PROCESS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // process_slot[5:0] burst_slot[10:6] process_id[26:11] arrival[42:27]
  // burst_ticks[58:43], zero fill [63:59]
  input  logic [fcfsd_pkg::IN_TDATA_W-1:0]  in_tdata,
  // operation
  input  logic         in_tuser,
  // final_burst
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // time_now[31:0] busy_cores[34:32] all_done[35] wait_total[67:36]
  // turnaround_total[99:68] busy_total[131:100] load_rejected[132]
  // last_finished_id[148:133], zero fill [151:149]
  output logic [fcfsd_pkg::OUT_TDATA_W-1:0] out_tdata
);

  fcfsd_pkg::cmd_t    cmd;
  fcfsd_pkg::sts_t    sts;
  fcfsd_pkg::item_t   item;
  fcfsd_pkg::result_t res;

  logic         out_valid_r, out_valid_nxt;
  logic [fcfsd_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic         out_room;
  logic         out_load;

  // unpack the input word
  assign item.op   = in_tuser;
  assign item.ps   = in_tdata[5:0];
  assign item.bs   = in_tdata[10:6];
  assign item.pid  = in_tdata[26:11];
  assign item.arr  = in_tdata[42:27];
  assign item.blen = in_tdata[58:43];
  assign item.fin  = in_tlast;

  // output register frees up in the same cycle it is taken
  assign out_room = !out_valid_r || out_tready;

  fcfsd_ctrl u_ctrl (
    .clk,
    .rst_n,
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .out_room (out_room),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_tready),
    .out_load (out_load)
  );

  fcfsd_dp #(
    .P (PROCESS_SLOTS),
    .C (CORES),
    .B (BURSTS_PER_PROCESS)
  ) u_dp (
    .clk,
    .rst_n,
    .cmd  (cmd),
    .item (item),
    .sts  (sts),
    .res  (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result word packing, first field in the low bits
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {3'b000, res.last_finished_id, res.load_rejected, res.busy_total,
                     res.turnaround_total, res.wait_total, res.all_done,
                     res.busy_cores, res.time_now};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // in_tready is low in the cycle after a word is accepted
  `ASSERT_NEXT(a_no_accept_twice, in_tvalid && in_tready, !in_tready, "input taken twice in a row")
  // a result is only written into a free or draining output register
  `ASSERT_SAME(a_load_has_room, out_load, !out_valid_r || out_tready, "result overwrote output")
  // a written result is presented on the next cycle
  `ASSERT_NEXT(a_load_shows, out_load, out_tvalid, "result not presented")
  // taking input and emitting a result never happen in the same cycle
  `ASSERT_SAME(a_ready_not_emit, in_tready, !out_load, "accept during emit")

endmodule
